[hw/rtl/nested_page_table_walker_macros.svh]
// Assertion macros shared by the nested page table walker RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef NESTED_PAGE_TABLE_WALKER_MACROS_SVH
`define NESTED_PAGE_TABLE_WALKER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define NPTW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nptw assertion failed");

// Next-cycle implication, disabled while reset is high.
`define NPTW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nptw assertion failed");

`endif

[hw/rtl/nptw_pkg.sv]
// Package for the nested page table walker: payload types, codes and
// address helper functions. Depends on nothing.
package nptw_pkg;

   localparam int PHYS_ADDR_BITS = 52;
   localparam int OUT_BITS       = 52;
   localparam int VA_BITS        = 48;

   localparam logic [1:0] KIND_VIRT = 2'd0;
   localparam logic [1:0] KIND_PHYS = 2'd1;
   localparam logic [1:0] KIND_RESP = 2'd2;

   localparam logic [1:0] RESULT_READ  = 2'd0;
   localparam logic [1:0] RESULT_DONE  = 2'd1;
   localparam logic [1:0] RESULT_FAULT = 2'd2;
   localparam logic [1:0] RESULT_BUSY  = 2'd3;

   localparam logic REG_GUEST_ROOT = 1'b0;
   localparam logic REG_EPT_ROOT   = 1'b1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] address;
      logic [63:0] entry;
      logic        read_error;
   } nptw_req_type;

   typedef struct packed {
      logic [1:0]          result_kind;
      logic [OUT_BITS-1:0] result_address;
      logic [1:0]          fault_level;
      logic                fault_in_ept;
   } nptw_rsp_type;

   // Nine-bit table index of an address at the given walk level.
   function automatic logic [8:0] tbl_index(logic [VA_BITS-1:0] a, logic [1:0] lvl);
      logic [8:0] idx;
      case (lvl)
         2'd0:    idx = a[47:39];
         2'd1:    idx = a[38:30];
         2'd2:    idx = a[29:21];
         default: idx = a[20:12];
      endcase
      return idx;
   endfunction

   // 4 KiB frame of an entry or root, bits above the physical width dropped.
   function automatic logic [OUT_BITS-1:0] frame_4k(logic [63:0] e);
      logic [OUT_BITS-1:0] f;
      f = '0;
      f[PHYS_ADDR_BITS-1:12] = e[PHYS_ADDR_BITS-1:12];
      return f;
   endfunction

   // Address of an 8-byte entry inside a table; the index never carries.
   function automatic logic [OUT_BITS-1:0] entry_addr(logic [OUT_BITS-1:0] base,
                                                      logic [8:0] idx);
      return {base[OUT_BITS-1:12], idx, 3'b000};
   endfunction

   // True when the entry ends the walk at this level.
   function automatic logic is_leaf(logic [63:0] e, logic [1:0] lvl);
      return (lvl == 2'd3) || (((lvl == 2'd1) || (lvl == 2'd2)) && e[7]);
   endfunction

   // Final address: 1 GiB page at level 1, 2 MiB at level 2, else 4 KiB.
   function automatic logic [OUT_BITS-1:0] leaf_address(logic [63:0] e, logic [1:0] lvl,
                                                        logic [VA_BITS-1:0] a);
      logic [OUT_BITS-1:0] f;
      f = frame_4k(e);
      case (lvl)
         2'd1:    f[29:0] = a[29:0];
         2'd2:    f[20:0] = a[20:0];
         default: f[11:0] = a[11:0];
      endcase
      return f;
   endfunction

endpackage

[hw/rtl/nptw_out_queue.sv]
// Two-entry result queue (output register plus skid slot) for the walker.
// Depends on nptw_pkg and nested_page_table_walker_macros.svh.
`include "nested_page_table_walker_macros.svh"

module nptw_out_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  nptw_pkg::nptw_rsp_type push_data,
   output logic                  full,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output nptw_pkg::nptw_rsp_type rsp_payload
);
   import nptw_pkg::*;

   logic         head_valid_ff, head_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   nptw_rsp_type head_ff, head_in;
   nptw_rsp_type skid_ff, skid_in;
   logic         pop;

   assign pop         = head_valid_ff && !rsp_stall;
   assign full        = skid_valid_ff;
   assign rsp_valid   = head_valid_ff;
   assign rsp_payload = head_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = push;
            skid_in       = push_data;
         end else begin
            head_valid_in = push;
            head_in       = push_data;
         end
      end else if (push) begin
         if (head_valid_ff) begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end else begin
            head_valid_in = 1'b1;
            head_in       = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   `NPTW_ASSERT_NOW(a_skid_needs_head, clock, reset, skid_valid_ff, head_valid_ff)
   `NPTW_ASSERT_NOW(a_no_push_when_full, clock, reset, push, !skid_valid_ff || pop)
   `NPTW_ASSERT_NEXT(a_skid_moves_up, clock, reset, skid_valid_ff && pop, head_valid_ff && (head_ff == $past(skid_ff)))

endmodule

[hw/rtl/nested_page_table_walker.sv]
// Nested four-level page table walker: each result is registered in the
// result queue before it reaches the rsp channel; one request is accepted
// per cycle while req_stall is low. A two-entry result queue lets requests
// flow while rsp stalls; req_stall rises only when both entries hold results.
// Reset is synchronous and active high: it clears the walk state, the roots
// and the result queue at once, with no clearing pass.
// Depends on nptw_pkg and nptw_out_queue.

module nested_page_table_walker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  nptw_pkg::nptw_req_type req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output nptw_pkg::nptw_rsp_type rsp_payload,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [3:0]             csr_paddr,
   input  logic [63:0]            csr_pwdata,
   output logic [63:0]            csr_prdata,
   output logic                   csr_pready
);
   import nptw_pkg::*;

   // Walk phases: idle, waiting on an extended entry, waiting on a guest entry.
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_EPT   = 2'd1;
   localparam logic [1:0] PH_GUEST = 2'd2;

   logic [63:0]        guest_root_ff, ept_root_ff;
   logic [1:0]         phase_ff, phase_in;
   logic [1:0]         guest_level_ff, guest_level_in;
   logic [1:0]         ept_level_ff, ept_level_in;
   logic               virt_ff, virt_in;
   logic [VA_BITS-1:0] req_addr_ff, req_addr_in;
   logic [VA_BITS-1:0] target_ff, target_in;

   logic               accept;
   logic               push;
   logic               full;
   logic               cfg_write;
   nptw_rsp_type       res;
   logic [OUT_BITS-1:0] tmp_addr;
   logic [1:0]         next_level;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = full;
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[3] == REG_EPT_ROOT) ? ept_root_ff : guest_root_ff;

   // Registers sit at byte offsets 0 and 8; bit 3 of the address selects one.
   always_ff @(posedge clock) begin
      if (reset) begin
         guest_root_ff <= '0;
         ept_root_ff   <= '0;
      end else if (cfg_write) begin
         if (csr_paddr[3] == REG_EPT_ROOT) begin
            ept_root_ff <= csr_pwdata;
         end else begin
            guest_root_ff <= csr_pwdata;
         end
      end
   end

   // At most one walk step per accepted request. Every entry address is a frame with
   // a scaled index in its low twelve bits, so the adds of the walk reduce to
   // bit concatenation. Only address bits 47 and below ever matter, so the
   // saved addresses are 48 bits wide.
   always_comb begin
      phase_in       = phase_ff;
      guest_level_in = guest_level_ff;
      ept_level_in   = ept_level_ff;
      virt_in        = virt_ff;
      req_addr_in    = req_addr_ff;
      target_in      = target_ff;
      push           = 1'b0;
      res            = '0;
      tmp_addr       = '0;
      next_level     = '0;
      if (accept) begin
         unique case (req_payload.kind) inside
            KIND_VIRT, KIND_PHYS: begin
               push = 1'b1;
               if (phase_ff != PH_IDLE) begin
                  // A new translation while a walk runs is turned away.
                  res.result_kind = RESULT_BUSY;
               end else begin
                  req_addr_in    = req_payload.address[VA_BITS-1:0];
                  virt_in        = (req_payload.kind == KIND_VIRT);
                  guest_level_in = 2'd0;
                  if (req_payload.kind == KIND_VIRT) begin
                     tmp_addr  = entry_addr(frame_4k(guest_root_ff),
                                            tbl_index(req_payload.address[VA_BITS-1:0],
                                                      2'd0));
                     target_in = tmp_addr[VA_BITS-1:0];
                  end else begin
                     target_in = req_payload.address[VA_BITS-1:0];
                  end
                  ept_level_in          = 2'd0;
                  phase_in              = PH_EPT;
                  res.result_kind       = RESULT_READ;
                  res.result_address    = entry_addr(frame_4k(ept_root_ff),
                                                     tbl_index(target_in, 2'd0));
               end
            end
            KIND_RESP: begin
               unique case (phase_ff)
                  PH_EPT: begin
                     push = 1'b1;
                     if (req_payload.read_error || !req_payload.entry[0]) begin
                        phase_in         = PH_IDLE;
                        res.result_kind  = RESULT_FAULT;
                        res.fault_level  = ept_level_ff;
                        res.fault_in_ept = 1'b1;
                     end else if (!is_leaf(req_payload.entry, ept_level_ff)) begin
                        next_level         = 2'(ept_level_ff + 2'd1);
                        ept_level_in       = next_level;
                        res.result_kind    = RESULT_READ;
                        res.result_address = entry_addr(frame_4k(req_payload.entry),
                                                        tbl_index(target_ff, next_level));
                     end else begin
                        res.result_address = leaf_address(req_payload.entry, ept_level_ff,
                                                          target_ff);
                        if (!virt_ff) begin
                           phase_in        = PH_IDLE;
                           res.result_kind = RESULT_DONE;
                        end else begin
                           // The extended walk located a guest entry: read it.
                           phase_in        = PH_GUEST;
                           res.result_kind = RESULT_READ;
                        end
                     end
                  end
                  PH_GUEST: begin
                     push = 1'b1;
                     if (req_payload.read_error || !req_payload.entry[0]) begin
                        phase_in        = PH_IDLE;
                        res.result_kind = RESULT_FAULT;
                        res.fault_level = guest_level_ff;
                     end else if (is_leaf(req_payload.entry, guest_level_ff)) begin
                        phase_in           = PH_IDLE;
                        res.result_kind    = RESULT_DONE;
                        res.result_address = leaf_address(req_payload.entry, guest_level_ff,
                                                          req_addr_ff);
                     end else begin
                        // Next guest table: its entry address goes through a
                        // fresh extended walk.
                        next_level         = 2'(guest_level_ff + 2'd1);
                        guest_level_in     = next_level;
                        tmp_addr           = entry_addr(frame_4k(req_payload.entry),
                                                        tbl_index(req_addr_ff, next_level));
                        target_in          = tmp_addr[VA_BITS-1:0];
                        ept_level_in       = 2'd0;
                        phase_in           = PH_EPT;
                        res.result_kind    = RESULT_READ;
                        res.result_address = entry_addr(frame_4k(ept_root_ff),
                                                        tbl_index(target_in, 2'd0));
                     end
                  end
                  default: begin
                     // A response with no walk running is dropped.
                     phase_in = PH_IDLE;
                  end
               endcase
            end
            default: begin
               // The unused kind code is ignored.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         guest_level_ff <= '0;
         ept_level_ff   <= '0;
         virt_ff        <= 1'b0;
         req_addr_ff    <= '0;
         target_ff      <= '0;
      end else begin
         phase_ff       <= phase_in;
         guest_level_ff <= guest_level_in;
         ept_level_ff   <= ept_level_in;
         virt_ff        <= virt_in;
         req_addr_ff    <= req_addr_in;
         target_ff      <= target_in;
      end
   end

   nptw_out_queue u_out_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_data   (res),
      .full        (full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
